// ----- rtl/core/jac_pkg.sv -----
// Shared types and constants of the joystick average and calibration block.
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

    localparam int CHANNELS = 4;
    localparam int AXES     = 3;
    localparam int FIELD_W  = 12;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 8;
    localparam int OFFSET_W = 12;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Gain is Q4.12, so the product carries twelve fraction bits.
    localparam int CAL_FRAC_BITS = 12;
    localparam int CAL_DIFF_W    = OFFSET_W + 1;
    localparam int CAL_PROD_W    = CAL_DIFF_W + GAIN_W;
    localparam int CAL_Q_W       = CAL_PROD_W - CAL_FRAC_BITS;

    localparam logic signed [CAL_Q_W-1:0] OUT_MAX  = CAL_Q_W'(2047);
    localparam logic signed [CAL_Q_W-1:0] OUT_MIN  = -CAL_Q_W'(2048);
    localparam logic        [FIELD_W-1:0] OUT_BIAS = 12'd2048;

    localparam logic [PERIOD_W-1:0] RST_EMIT_PERIOD = 8'd8;
    localparam logic [OFFSET_W-1:0] RST_AXIS0_OFFSET = 12'd2064;
    localparam logic [OFFSET_W-1:0] RST_AXIS1_OFFSET = 12'd2063;
    localparam logic [OFFSET_W-1:0] RST_AXIS2_OFFSET = 12'd2003;
    localparam logic signed [GAIN_W-1:0] RST_AXIS0_GAIN = 16'sd4100;
    localparam logic signed [GAIN_W-1:0] RST_AXIS1_GAIN = 16'sd4103;
    localparam logic signed [GAIN_W-1:0] RST_AXIS2_GAIN = -16'sd4268;

    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS0_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS1_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS2_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS0_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS1_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS2_GAIN = 3'd6;

    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [FIELD_W-1:0] sample_ch0;
        logic [FIELD_W-1:0] sample_ch1;
        logic [FIELD_W-1:0] sample_ch2;
        logic [FIELD_W-1:0] sample_ch3;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] axis0_value;
        logic [FIELD_W-1:0] axis1_value;
        logic [FIELD_W-1:0] axis2_value;
        logic [FIELD_W-1:0] channel3_average;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/jac_window.sv -----
// Sample ring, running window sums and emit timing.
`timescale 1ns / 1ps
`default_nettype none

module jac_window
    import jac_pkg::*;
#(
    parameter int WINDOW_LEN = 7,
    parameter int SAMPLE_W   = 12,
    parameter int SUM_W      = 15
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_load,
    input  wire t_in_item            i_item,
    input  wire logic [PERIOD_W-1:0] i_period,
    output logic                     o_emit,
    output logic [SUM_W-1:0]         o_sum [CHANNELS]
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [SAMPLE_W-1:0] r_ring [WINDOW_LEN][CHANNELS];
    logic [SUM_W-1:0]    r_sum  [CHANNELS];
    logic [SUM_W-1:0]    n_sum  [CHANNELS];
    logic [SUM_W-1:0]    r_snap [CHANNELS];
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [TIME_W-1:0]   r_last;
    logic [TIME_W-1:0]   elapsed;
    logic [SAMPLE_W-1:0] sample [CHANNELS];

    always_comb begin
        sample[0] = i_item.sample_ch0[SAMPLE_W-1:0];
        sample[1] = i_item.sample_ch1[SAMPLE_W-1:0];
        sample[2] = i_item.sample_ch2[SAMPLE_W-1:0];
        sample[3] = i_item.sample_ch3[SAMPLE_W-1:0];
    end

    // The window sum drops the sample being overwritten and adds the new one.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_sum[c] = r_sum[c] - SUM_W'(r_ring[r_slot][c]) + SUM_W'(sample[c]);
        end
    end

    assign n_slot  = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
    assign elapsed = i_item.tick_time - r_last;
    assign o_emit  = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, i_period});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_last <= '0;
            for (int s = 0; s < WINDOW_LEN; s++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_ring[s][c] <= '0;
                end
            end
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_accept) begin
            r_slot <= n_slot;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ring[r_slot][c] <= sample[c];
                r_sum[c]          <= n_sum[c];
            end
            if (o_emit) begin
                r_last <= i_item.tick_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_snap[c] <= n_sum[c];
            end
        end
    end

    assign o_sum = r_snap;

endmodule

`default_nettype wire

// ----- rtl/core/jac_avg.sv -----
// Window average: division of the sums by the window length via a reciprocal.
`timescale 1ns / 1ps
`default_nettype none

module jac_avg
    import jac_pkg::*;
#(
    parameter int WINDOW_LEN = 7,
    parameter int SAMPLE_W   = 12,
    parameter int SUM_W      = 15
) (
    input  wire logic                i_clk,
    input  wire logic                i_load,
    input  wire logic [SUM_W-1:0]    i_sum [CHANNELS],
    output logic      [SAMPLE_W-1:0] o_avg [CHANNELS]
);

    // Rounded-up reciprocal with enough extra bits to be exact for any sum.
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = SHIFT + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PROD_W-1:0]   prod  [CHANNELS];
    logic [SAMPLE_W-1:0] r_avg [CHANNELS];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            prod[c] = PROD_W'(i_sum[c]) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_avg[c] <= prod[c][SHIFT +: SAMPLE_W];
            end
        end
    end

    assign o_avg = r_avg;

endmodule

`default_nettype wire

// ----- rtl/core/jac_cal.sv -----
// Offset and gain calibration of one axis, in two registered steps.
`timescale 1ns / 1ps
`default_nettype none

module jac_cal
    import jac_pkg::*;
#(
    parameter int SAMPLE_W = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_load_prod,
    input  wire logic                     i_load_out,
    input  wire logic [SAMPLE_W-1:0]      i_avg,
    input  wire logic [OFFSET_W-1:0]      i_offset,
    input  wire logic signed [GAIN_W-1:0] i_gain,
    output logic      [FIELD_W-1:0]       o_value
);

    logic signed [CAL_DIFF_W-1:0] diff;
    logic signed [CAL_PROD_W-1:0] n_prod;
    logic signed [CAL_PROD_W-1:0] r_prod;
    logic signed [CAL_PROD_W-1:0] biased;
    logic signed [CAL_Q_W-1:0]    quot;
    logic signed [CAL_Q_W-1:0]    clipped;
    logic        [FIELD_W-1:0]    r_value;

    assign diff   = $signed({1'b0, OFFSET_W'(i_avg)}) - $signed({1'b0, i_offset});
    assign n_prod = CAL_PROD_W'(diff) * CAL_PROD_W'(i_gain);

    // A negative product is biased up first so the shift truncates toward zero.
    assign biased = r_prod[CAL_PROD_W-1]
                  ? r_prod + CAL_PROD_W'((1 << CAL_FRAC_BITS) - 1) : r_prod;
    assign quot   = CAL_Q_W'(biased >>> CAL_FRAC_BITS);

    always_comb begin
        if (quot > OUT_MAX) begin
            clipped = OUT_MAX;
        end else if (quot < OUT_MIN) begin
            clipped = OUT_MIN;
        end else begin
            clipped = quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_prod <= n_prod;
        end
        if (i_load_out) begin
            r_value <= clipped[FIELD_W-1:0] + OUT_BIAS;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/core/joystick_average_calibrate.sv -----
// Top level of the joystick window average and axis calibration block.
`timescale 1ns / 1ps
`default_nettype none

// Every request carries a timestamp and four ADC samples; one request per cycle
// is sustained unless the pipeline is full and the output stalled. Each request
// updates a ring of the last WINDOW_LEN sample sets and a running sum per channel;
// when at least emit_period ticks have passed since the last result, it yields one
// result through the registered window snapshot, reciprocal multiply for the
// average, gain multiply and saturation into the output register. A waiting result
// does not stop new requests while the pipeline has a free stage. Configuration is
// written through a plain write port; the user must write it only while idle, the block itself does not enforce this.
module joystick_average_calibrate
    import jac_pkg::*;
#(
    parameter int WINDOW_LEN  = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Input fields are twelve bits, so no more than twelve sample bits remain.
    localparam int SAMPLE_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);

    logic [PERIOD_W-1:0]       r_period;
    logic [OFFSET_W-1:0]       r_offset [AXES];
    logic signed [GAIN_W-1:0]  r_gain   [AXES];

    logic r_v1, r_v2, r_v3, r_vo;
    logic load1, load2, load3, load_o;
    logic accept, emit;

    logic [SUM_W-1:0]    sum [CHANNELS];
    logic [SAMPLE_W-1:0] avg [CHANNELS];
    logic [FIELD_W-1:0]  axis_value [AXES];
    logic [FIELD_W-1:0]  r_ch3_s3;
    logic [FIELD_W-1:0]  r_ch3_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= RST_EMIT_PERIOD;
            r_offset[0] <= RST_AXIS0_OFFSET;
            r_offset[1] <= RST_AXIS1_OFFSET;
            r_offset[2] <= RST_AXIS2_OFFSET;
            r_gain[0]   <= RST_AXIS0_GAIN;
            r_gain[1]   <= RST_AXIS1_GAIN;
            r_gain[2]   <= RST_AXIS2_GAIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_EMIT_PERIOD:  r_period    <= i_cfg_data[PERIOD_W-1:0];
                CFG_AXIS0_OFFSET: r_offset[0] <= i_cfg_data[OFFSET_W-1:0];
                CFG_AXIS1_OFFSET: r_offset[1] <= i_cfg_data[OFFSET_W-1:0];
                CFG_AXIS2_OFFSET: r_offset[2] <= i_cfg_data[OFFSET_W-1:0];
                CFG_AXIS0_GAIN:   r_gain[0]   <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_AXIS1_GAIN:   r_gain[1]   <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_AXIS2_GAIN:   r_gain[2]   <= $signed(i_cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its content moves on.
    assign load_o = !r_vo || i_out_ready;
    assign load3  = !r_v3 || load_o;
    assign load2  = !r_v2 || load3;
    assign load1  = !r_v1 || load2;

    assign o_in_ready = load1;
    assign accept     = i_in_valid && load1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= accept && emit;
            end
            if (load2) begin
                r_v2 <= r_v1;
            end
            if (load3) begin
                r_v3 <= r_v2;
            end
            if (load_o) begin
                r_vo <= r_v3;
            end
        end
    end

    jac_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_W   (SAMPLE_W),
        .SUM_W      (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_load   (load1),
        .i_item   (i_in_data),
        .i_period (r_period),
        .o_emit   (emit),
        .o_sum    (sum)
    );

    jac_avg #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_W   (SAMPLE_W),
        .SUM_W      (SUM_W)
    ) u_avg (
        .i_clk  (i_clk),
        .i_load (load2),
        .i_sum  (sum),
        .o_avg  (avg)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        jac_cal #(
            .SAMPLE_W (SAMPLE_W)
        ) u_cal (
            .i_clk       (i_clk),
            .i_load_prod (load3),
            .i_load_out  (load_o),
            .i_avg       (avg[a]),
            .i_offset    (r_offset[a]),
            .i_gain      (r_gain[a]),
            .o_value     (axis_value[a])
        );
    end

    // The channel 3 average never exceeds the twelve-bit field, so it passes as is.
    always_ff @(posedge i_clk) begin
        if (load3) begin
            r_ch3_s3 <= FIELD_W'(avg[3]);
        end
        if (load_o) begin
            r_ch3_out <= r_ch3_s3;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_data  = '{
        axis0_value:      axis_value[0],
        axis1_value:      axis_value[1],
        axis2_value:      axis_value[2],
        channel3_average: r_ch3_out
    };

endmodule

`default_nettype wire

// ----- rtl/core/jac_checker.sv -----
// Port-level assertions of the joystick block and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jac_checker
    import jac_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // Reset empties the pipeline on the following cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With the output free to move, every stage moves, so a request is taken.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("request refused while the output is free");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind joystick_average_calibrate jac_checker u_jac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
